[src/sfwm_pkg.sv]
// ----------------------------------------------------------------------------
// sfwm_pkg
// types, codes and sizes shared by the servo fault/warning manager
// ----------------------------------------------------------------------------
package sfwm_pkg;

  // number of implemented warning flag bits (1 to 16 on this port width)
  localparam int unsigned WarnFlagBits = 16;
  // groups of eight display numbers covered by the fault mask (1 to 8)
  localparam int unsigned MaskGroups   = 8;
  localparam int unsigned MaskDisplays = MaskGroups * 8;

  localparam int unsigned FaultMaskW = 64;
  localparam int unsigned MaskIdxW   = $clog2(FaultMaskW);
  localparam int unsigned WarnOutW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_WARN   = 2'd1,
    ST_FAULT  = 2'd2,
    ST_BOTH   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REQ_REPORT = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_TICK   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    LVL_ONE  = 2'd0,
    LVL_TWO  = 2'd1,
    LVL_WARN = 2'd2
  } fault_level_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAULT_MASK     = 1'd0,
    CFG_ALL_RESETTABLE = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] fault_level;
    logic [3:0] fault_priority;
    logic [7:0] fault_display;
    logic [3:0] warn_index;
    logic       fault_resettable;
    logic       reset_request;
    logic       ctrl_reset_bit;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          fault_state;
    logic                warn_out;
    logic                alarm_out;
    logic                shutdown_pulse;
    logic [7:0]          shown_code;
    logic [WarnOutW-1:0] warn_flags;
    logic                report_masked;
    logic                reset_done;
  } out_res_t;

  typedef struct packed {
    status_e                 status;
    logic [WarnFlagBits-1:0] warnings;
    logic [3:0]              priority_lvl;
    logic                    resettable;
    logic [7:0]              shown;
    logic                    last_ctrl;
    logic                    warn;
    logic                    alarm;
  } mgr_state_t;

  typedef struct packed {
    logic [FaultMaskW-1:0] fault_mask;
    logic                  all_resettable;
  } mgr_cfg_t;

endpackage

[src/servo_fault_warning_manager.sv]
// ----------------------------------------------------------------------------
// servo_fault_warning_manager
// fault and warning state keeper of a servo drive
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i / in_stall_o / in_data_i carries one request:
//   a fault or warning report, a warning clear, or a millisecond tick
//   every request gives exactly one result on out_valid_o / out_stall_i /
//   out_data_o, in request order
//   the result is valid in the cycle after the request is accepted
//   throughput: one request per cycle; the state update is a single pass of
//   compare-and-select logic between the request and the result register
//   when the receiver stalls, the result register holds its value and the
//   input stalls only while that register is full and not being drained
//   config port cfg_valid_i / cfg_ready_o writes fault_mask (index 0) or
//   all_resettable (index 1); it is always ready
//   reset clears the state to normal, all flags and config to zero, and
//   empties the result register; no clearing pass is needed
// ----------------------------------------------------------------------------
module servo_fault_warning_manager
  import sfwm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_req_t            in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_res_t           out_data_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  mgr_state_t state_q, state_d;
  mgr_cfg_t   cfg_q;
  out_res_t   res_d, res_q;
  logic       out_valid_q;
  logic       in_accept;

  // result register can take a new request when empty or draining
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  sfwm_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .req_i   (in_data_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FAULT_MASK:     cfg_q.fault_mask     <= cfg_data_i;
        CFG_ALL_RESETTABLE: cfg_q.all_resettable <= cfg_data_i[0];
        default:            ;
      endcase
    end
  end

  // manager state, updated once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // the shown result always mirrors the stored state
  a_state_mirror : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.fault_state == state_q.status &&
                     res_q.shown_code == state_q.shown &&
                     res_q.warn_flags == WarnOutW'(state_q.warnings)))
    else $error("result does not match stored state");

  // a masked report neither shuts down nor resets
  a_masked_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.report_masked) |->
      (!res_q.shutdown_pulse && !res_q.reset_done))
    else $error("masked report had an effect");

  // a reset leaves normal state with a blank display
  a_reset_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.reset_done) |->
      (res_q.fault_state == ST_NORMAL && res_q.shown_code == 8'd0))
    else $error("reset left residual fault state");

  // state changes only on an accepted request
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(state_q))
    else $error("state changed without a request");

  // a shutdown pulse always comes with a fault state
  a_shutdown_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.shutdown_pulse) |-> res_q.fault_state[1])
    else $error("shutdown without fault state");

endmodule

[src/sfwm_step.sv]
// ----------------------------------------------------------------------------
// sfwm_step
// next-state and result logic for one request of the fault manager
// ----------------------------------------------------------------------------
module sfwm_step
  import sfwm_pkg::*;
(
  input  mgr_state_t state_i,
  input  mgr_cfg_t   cfg_i,
  input  in_req_t    req_i,
  output mgr_state_t state_o,
  output out_res_t   res_o
);

  logic [WarnFlagBits-1:0] wbit;
  logic                    is_warn;
  logic                    is_lvl_one;
  logic                    masked;
  logic [MaskIdxW-1:0]     mask_idx;
  logic                    ctrl_edge;
  logic                    blocked;
  logic                    shutdown;
  logic                    done;
  status_e                 st_rec;

  assign is_warn    = (req_i.fault_level == LVL_WARN);
  assign is_lvl_one = (req_i.fault_level == LVL_ONE);
  assign wbit       = (32'(req_i.warn_index) < WarnFlagBits) ?
                      (WarnFlagBits'(1) << req_i.warn_index) : '0;
  assign mask_idx   = MaskIdxW'(req_i.fault_display - 8'd1);
  assign masked     = !is_warn && (req_i.fault_display != 8'd0) &&
                      (32'(req_i.fault_display) <= MaskDisplays) &&
                      cfg_i.fault_mask[mask_idx];
  assign ctrl_edge  = req_i.ctrl_reset_bit && !state_i.last_ctrl;

  // auto recovery when no warnings remain: warn -> normal, both -> fault
  always_comb begin
    st_rec = state_i.status;
    if (state_i.warnings == '0) begin
      if (state_i.status == ST_WARN) st_rec = ST_NORMAL;
      if (state_i.status == ST_BOTH) st_rec = ST_FAULT;
    end
  end

  assign blocked = !cfg_i.all_resettable && !state_i.resettable &&
                   (st_rec == ST_FAULT || st_rec == ST_BOTH);

  always_comb begin
    state_o  = state_i;
    shutdown = 1'b0;
    done     = 1'b0;
    unique case (req_i.req_type)
      REQ_REPORT: begin
        if (masked) begin
          // dropped
        end else if (state_i.status == ST_NORMAL || state_i.status == ST_WARN) begin
          if (is_warn) begin
            state_o.warnings = state_i.warnings | wbit;
            state_o.status   = ST_WARN;
          end else begin
            state_o.status       = (state_i.status == ST_NORMAL) ? ST_FAULT : ST_BOTH;
            state_o.priority_lvl = req_i.fault_priority;
            state_o.resettable   = req_i.fault_resettable;
            shutdown             = is_lvl_one;
          end
          state_o.shown = req_i.fault_display;
        end else begin
          if (req_i.fault_priority < state_i.priority_lvl) begin
            // more urgent report takes over the stored fault
            state_o.priority_lvl = req_i.fault_priority;
            state_o.resettable   = req_i.fault_resettable;
            state_o.shown        = req_i.fault_display;
            shutdown             = is_lvl_one;
          end else if (is_warn) begin
            state_o.status   = ST_BOTH;
            state_o.warnings = state_i.warnings | wbit;
          end
        end
      end
      REQ_CLEAR: begin
        if (state_i.shown == req_i.fault_display) state_o.shown = 8'd0;
        state_o.warnings = state_i.warnings & ~wbit;
      end
      REQ_TICK: begin
        state_o.warn  = state_i.status[0];
        state_o.alarm = state_i.status[1];
        if (state_i.status != ST_NORMAL) begin
          state_o.status = st_rec;
          if (!blocked && (req_i.reset_request || ctrl_edge)) begin
            state_o.status       = ST_NORMAL;
            state_o.priority_lvl = 4'd0;
            state_o.resettable   = 1'b0;
            state_o.shown        = 8'd0;
            done                 = 1'b1;
          end
        end
        state_o.last_ctrl = req_i.ctrl_reset_bit;
      end
      default: begin
        // unused request code leaves the state alone
      end
    endcase
  end

  always_comb begin
    res_o                = '0;
    res_o.fault_state    = state_o.status;
    res_o.warn_out       = state_o.warn;
    res_o.alarm_out      = state_o.alarm;
    res_o.shutdown_pulse = shutdown;
    res_o.shown_code     = state_o.shown;
    res_o.warn_flags     = WarnOutW'(state_o.warnings);
    res_o.report_masked  = (req_i.req_type == REQ_REPORT) && masked;
    res_o.reset_done     = done;
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// request/result check of the servo fault and warning manager
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a clocked driver that idles at random
// a clocked monitor takes every accepted request and runs it through a
// behavioral copy of the manager (state plus configuration) to get the
// expected result, then checks every accepted result field by field
// the run steps through several mask / reset-mode settings, each written
// while nothing is in flight, starting with a directed request sequence
// ----------------------------------------------------------------------------
module testbench
  import sfwm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // codes outside the package enums
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [1:0] LvlThree  = 2'd3;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomPerSet = 265;
  localparam int unsigned NumSettings  = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_req_t            in_data = '0;
  // result side
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_res_t           out_data;
  // register writes
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CFG_FAULT_MASK;
  logic [63:0]        cfg_data = '0;

  servo_fault_warning_manager dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  // request and result stores
  in_req_t     pending_q[$];
  out_res_t    expected_q[$];
  out_res_t    oldest;
  bit          in_fire;
  int unsigned gap_pct = 33;

  // run statistics
  int unsigned mismatches;
  int unsigned requests_taken;
  int unsigned masked_seen;
  int unsigned shutdowns_seen;
  int unsigned resets_seen;
  int unsigned cycle_count;

  // ---------------------------------------------------------------------------
  // behavioral copy of the manager: configuration and state
  // ---------------------------------------------------------------------------
  logic [63:0]             mask_cfg;
  logic                    all_reset_cfg;
  status_e                 mgr_status;
  logic [WarnFlagBits-1:0] mgr_warnings;
  logic [3:0]              mgr_priority;
  logic                    mgr_resettable;
  logic [7:0]              mgr_shown;
  logic                    mgr_last_ctrl;
  logic                    mgr_warn_out;
  logic                    mgr_alarm_out;

  // applies one request to the copied state and returns the result it gives
  function automatic out_res_t advance_manager(in_req_t r);
    out_res_t                res;
    logic [WarnFlagBits-1:0] warn_sel;
    logic                    is_warn;
    logic                    edge_hit;
    logic                    blocked;
    res = '0;
    warn_sel = '0;
    // an index past the implemented flags addresses nothing
    if (32'(r.warn_index) < WarnFlagBits) begin
      warn_sel[r.warn_index] = 1'b1;
    end
    is_warn = (r.fault_level == LVL_WARN);

    case (r.req_type)
      REQ_REPORT: begin
        // warnings and displays outside 1..MaskDisplays are never masked
        if (!is_warn && r.fault_display != 8'd0 && 32'(r.fault_display) <= MaskDisplays &&
            mask_cfg[MaskIdxW'(r.fault_display - 8'd1)]) begin
          res.report_masked = 1'b1;
        end else if (mgr_status == ST_NORMAL || mgr_status == ST_WARN) begin
          if (is_warn) begin
            mgr_warnings |= warn_sel;
            mgr_status = ST_WARN;
          end else begin
            // level three falls through here as a level-2 fault
            mgr_status = (mgr_status == ST_NORMAL) ? ST_FAULT : ST_BOTH;
            mgr_priority = r.fault_priority;
            mgr_resettable = r.fault_resettable;
            res.shutdown_pulse = (r.fault_level == LVL_ONE);
          end
          mgr_shown = r.fault_display;
        end else if (r.fault_priority < mgr_priority) begin
          // more urgent report in a fault state, warnings included
          mgr_priority = r.fault_priority;
          mgr_resettable = r.fault_resettable;
          mgr_shown = r.fault_display;
          res.shutdown_pulse = (r.fault_level == LVL_ONE);
        end else if (is_warn) begin
          mgr_status = ST_BOTH;
          mgr_warnings |= warn_sel;
        end
      end
      REQ_CLEAR: begin
        if (mgr_shown == r.fault_display) begin
          mgr_shown = 8'd0;
        end
        mgr_warnings &= ~warn_sel;
      end
      REQ_TICK: begin
        // outputs latch the state as it stands before recovery and reset
        mgr_warn_out = (mgr_status == ST_WARN || mgr_status == ST_BOTH);
        mgr_alarm_out = (mgr_status == ST_FAULT || mgr_status == ST_BOTH);
        if (mgr_status != ST_NORMAL) begin
          edge_hit = r.ctrl_reset_bit && !mgr_last_ctrl;
          // automatic recovery once no warning is left
          if (mgr_warnings == '0 && mgr_status != ST_FAULT) begin
            mgr_status = (mgr_status == ST_WARN) ? ST_NORMAL : ST_FAULT;
          end
          blocked = !all_reset_cfg && !mgr_resettable &&
                    (mgr_status == ST_FAULT || mgr_status == ST_BOTH);
          if (!blocked && (r.reset_request || edge_hit)) begin
            mgr_status = ST_NORMAL;
            mgr_priority = 4'd0;
            mgr_resettable = 1'b0;
            mgr_shown = 8'd0;
            res.reset_done = 1'b1;
          end
        end
        mgr_last_ctrl = r.ctrl_reset_bit;
      end
      default: begin
        // unused request type only reports the current state
      end
    endcase

    res.fault_state = mgr_status;
    res.warn_out = mgr_warn_out;
    res.alarm_out = mgr_alarm_out;
    res.shown_code = mgr_shown;
    res.warn_flags[WarnFlagBits-1:0] = mgr_warnings;
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: presents the next pending request at the falling edge,
  // keeps a stalled request steady, and also randomizes the result stall
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_fire = 1'b0;
      out_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted request, checks each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(advance_manager(in_data));
        requests_taken++;
        in_fire = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result accepted with no request outstanding");
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("fault_state", 16'(oldest.fault_state), 16'(out_data.fault_state));
          check_field("warn_out", 16'(oldest.warn_out), 16'(out_data.warn_out));
          check_field("alarm_out", 16'(oldest.alarm_out), 16'(out_data.alarm_out));
          check_field("shutdown_pulse", 16'(oldest.shutdown_pulse),
                      16'(out_data.shutdown_pulse));
          check_field("shown_code", 16'(oldest.shown_code), 16'(out_data.shown_code));
          check_field("warn_flags", oldest.warn_flags, out_data.warn_flags);
          check_field("report_masked", 16'(oldest.report_masked),
                      16'(out_data.report_masked));
          check_field("reset_done", 16'(oldest.reset_done), 16'(out_data.reset_done));
          masked_seen += out_data.report_masked;
          shutdowns_seen += out_data.shutdown_pulse;
          resets_seen += out_data.reset_done;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_req_t make_request(logic [1:0] req, logic [1:0] lvl,
                                           logic [3:0] prio, logic [7:0] disp,
                                           logic [3:0] widx, logic rsbl,
                                           logic rreq, logic ctrl);
    in_req_t r;
    r.req_type = req;
    r.fault_level = lvl;
    r.fault_priority = prio;
    r.fault_display = disp;
    r.warn_index = widx;
    r.fault_resettable = rsbl;
    r.reset_request = rreq;
    r.ctrl_reset_bit = ctrl;
    return r;
  endfunction

  // mostly reports and ticks with rare resets so faults live long enough
  // to be replaced, joined by warnings and cleared; a few unused codes
  function automatic in_req_t random_request();
    in_req_t     r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.req_type = REQ_REPORT;
    end else if (pick < 60) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 97) begin
      r.req_type = REQ_TICK;
    end else begin
      r.req_type = ReqUnused;
    end
    pick = $urandom_range(9);
    if (pick < 3) begin
      r.fault_level = LVL_ONE;
    end else if (pick < 6) begin
      r.fault_level = LVL_TWO;
    end else if (pick < 9) begin
      r.fault_level = LVL_WARN;
    end else begin
      r.fault_level = LvlThree;
    end
    r.fault_priority = 4'($urandom_range(15));
    // a small pool of display numbers so clears often hit the shown one
    case ($urandom_range(9))
      0: r.fault_display = 8'd0;
      1: r.fault_display = 8'($urandom_range(255, 65));
      2: r.fault_display = 8'($urandom_range(64, 57));
      default: r.fault_display = 8'($urandom_range(8, 1));
    endcase
    r.warn_index = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
                                               4'($urandom_range(5));
    r.fault_resettable = 1'($urandom_range(1));
    r.reset_request = ($urandom_range(9) == 0);
    r.ctrl_reset_bit = ($urandom_range(3) == 0);
    return r;
  endfunction

  task automatic write_register(cfg_reg_e idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FAULT_MASK) begin
      mask_cfg = value;
    end else begin
      all_reset_cfg = value[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // holds until no request is pending or in flight
  task automatic wait_drained();
    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_directed();
    // reset in normal; the control bit goes high
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b1));
    // warning with display 0, top index and lowest urgency
    pending_q.push_back(make_request(REQ_REPORT, LVL_WARN, 4'd15, 8'd0, 4'd15, 1'b1, 1'b1, 1'b1));
    // reset while only warning: back to normal, bits kept
    pending_q.push_back(make_request(REQ_TICK, LVL_WARN, 4'd0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    pending_q.push_back(make_request(REQ_CLEAR, LVL_WARN, 4'd0, 8'd0, 4'd15, 1'b0, 1'b0, 1'b0));
    // level-1 fault on an unmaskable display
    pending_q.push_back(make_request(REQ_REPORT, LVL_ONE, 4'd8, 8'd255, 4'd0, 1'b0, 1'b0, 1'b0));
    // level three, more urgent: replaces the stored fault
    pending_q.push_back(make_request(REQ_REPORT, LvlThree, 4'd3, 8'd64, 4'd0, 1'b0, 1'b0, 1'b0));
    // urgent warning in fault replaces the stored fault
    pending_q.push_back(make_request(REQ_REPORT, LVL_WARN, 4'd2, 8'd200, 4'd5, 1'b0, 1'b0, 1'b0));
    // ordinary warning in fault: fault plus warning
    pending_q.push_back(make_request(REQ_REPORT, LVL_WARN, 4'd15, 8'd9, 4'd5, 1'b1, 1'b0, 1'b0));
    // less urgent fault changes nothing
    pending_q.push_back(make_request(REQ_REPORT, LVL_ONE, 4'd15, 8'd1, 4'd0, 1'b1, 1'b0, 1'b0));
    // reset blocked by a non-resettable fault
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b1));
    // unused request type with every other bit set
    pending_q.push_back(make_request(ReqUnused, LvlThree, 4'd15, 8'd255, 4'd15, 1'b1, 1'b1, 1'b1));
    pending_q.push_back(make_request(REQ_CLEAR, LVL_ONE, 4'd0, 8'd200, 4'd5, 1'b0, 1'b0, 1'b0));
    // no warnings left: fault plus warning drops to fault
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(make_request(REQ_REPORT, LVL_ONE, 4'd0, 8'd1, 4'd0, 1'b1, 1'b0, 1'b0));
    // control-word rising edge clears the resettable fault
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b1));
    pending_q.push_back(make_request(REQ_REPORT, LVL_TWO, 4'd0, 8'd128, 4'd3, 1'b1, 1'b0, 1'b0));
    // control bit held high: no edge
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b1));
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    // warning that recovers on its own once cleared
    pending_q.push_back(make_request(REQ_REPORT, LVL_WARN, 4'd7, 8'd100, 4'd0, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(make_request(REQ_CLEAR, LVL_WARN, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    pending_q.push_back(make_request(REQ_TICK, LVL_ONE, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // sequence: reset, then one phase per setting; config only when drained
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] mask_set[NumSettings];
    logic        reset_mode[NumSettings];
    mask_set[0] = 64'h0;                    reset_mode[0] = 1'b0;
    mask_set[1] = '1;                       reset_mode[1] = 1'b1;
    mask_set[2] = {$urandom(), $urandom()}; reset_mode[2] = 1'b0;
    mask_set[3] = 64'h8000_0000_0000_0001;  reset_mode[3] = 1'b1;
    mask_set[4] = {$urandom(), $urandom()}; reset_mode[4] = 1'b1;
    mask_set[5] = 64'h0000_0000_0000_00ff;  reset_mode[5] = 1'b0;

    // copied state starts at its reset values
    mask_cfg = '0;
    all_reset_cfg = 1'b0;
    mgr_status = ST_NORMAL;
    mgr_warnings = '0;
    mgr_priority = 4'd0;
    mgr_resettable = 1'b0;
    mgr_shown = 8'd0;
    mgr_last_ctrl = 1'b0;
    mgr_warn_out = 1'b0;
    mgr_alarm_out = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NumSettings; ph++) begin
      // the sender stays paused here until every result is back
      wait_drained();
      write_register(CFG_FAULT_MASK, mask_set[ph]);
      write_register(CFG_ALL_RESETTABLE, {63'd0, reset_mode[ph]});
      // one setting runs with no idling on either side
      gap_pct = (ph == 2) ? 0 : 33;
      if (ph == 0) begin
        queue_directed();
      end
      for (int n = 0; n < RandomPerSet; n++) begin
        pending_q.push_back(random_request());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d requests over %0d mask and reset-mode settings",
             requests_taken, NumSettings);
    $display("seen %0d masked reports, %0d shutdown pulses, %0d fault resets",
             masked_seen, shutdowns_seen, resets_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
